FILE: hw/rtl/ogpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Ogg page demux core.
// Used by ogpd_ctrl, ogpd_dp and the top level; depends on nothing.
package ogpd_pkg;

	localparam logic [7:0] MAGIC_O    = 8'h4F;
	localparam logic [7:0] MAGIC_G    = 8'h67;
	localparam logic [7:0] MAGIC_S    = 8'h53;
	localparam logic [4:0] HDR_FIRST  = 5'd4;
	localparam logic [4:0] HDR_LAST   = 5'd26;
	localparam logic [4:0] GRAN_LO    = 5'd6;
	localparam logic [4:0] GRAN_HI    = 5'd13;
	localparam logic [7:0] SEG_FULL   = 8'd255;
	localparam logic [4:0] ID_MIN_LEN = 5'd30;
	localparam logic [6:0] DIV_STEPS  = 7'd64;

	function automatic logic [7:0] vorbis_char(input logic [2:0] k);
		logic [7:0] c;
		case (k)
			3'd0:    c = 8'h01;
			3'd1:    c = 8'h76;
			3'd2:    c = 8'h6F;
			3'd3:    c = 8'h72;
			3'd4:    c = 8'h62;
			3'd5:    c = 8'h69;
			3'd6:    c = 8'h73;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] magic_char(input logic [1:0] m);
		logic [7:0] c;
		case (m)
			2'd0:    c = MAGIC_O;
			2'd1:    c = MAGIC_G;
			2'd2:    c = MAGIC_G;
			default: c = MAGIC_S;
		endcase
		return c;
	endfunction

	typedef enum logic [8:0] {
		ST_HUNT     = 9'b000000001,
		ST_HDR      = 9'b000000010,
		ST_TBL      = 9'b000000100,
		ST_DIV      = 9'b000001000,
		ST_SCAN_RD  = 9'b000010000,
		ST_SCAN_CHK = 9'b000100000,
		ST_PAY      = 9'b001000000,
		ST_SEGEND   = 9'b010000000,
		ST_EMIT     = 9'b100000000
	} state_t;

	typedef struct packed {
		logic hunt_acc;
		logic hdr_acc;
		logic tbl_acc;
		logic div_start;
		logic div_step;
		logic scan_first;
		logic scan_rd;
		logic scan_close;
		logic scan_found;
		logic scan_stop;
		logic pay_acc;
		logic seg_end;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic magic_done;
		logic hdr_last;
		logic byte_zero;
		logic tbl_last;
		logic div_done;
		logic scan_end;
		logic scan_nz;
		logic rem_last;
		logic res_need;
		logic out_free;
	} sts_t;

endpackage

FILE: hw/rtl/ogpd_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the Ogg page demux core.
// Depends on ogpd_pkg; drives commands into ogpd_dp and reads its status.
module ogpd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ogpd_pkg::sts_t sts,
	output ogpd_pkg::cmd_t cmd
);
	import ogpd_pkg::*;

	state_t st_q, st_nxt;
	logic   ret_hunt_q, ret_hunt_nxt;

	always_comb begin
		cmd          = '0;
		st_nxt       = st_q;
		in_ready     = 1'b0;
		ret_hunt_nxt = ret_hunt_q;
		case (st_q)
			ST_HUNT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.hunt_acc = 1'b1;
					if (sts.magic_done) st_nxt = ST_HDR;
				end
			end
			ST_HDR: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.hdr_acc = 1'b1;
					if (sts.hdr_last) st_nxt = sts.byte_zero ? ST_HUNT : ST_TBL;
				end
			end
			ST_TBL: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.tbl_acc = 1'b1;
					if (sts.tbl_last) begin
						cmd.div_start = 1'b1;
						st_nxt        = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.scan_first = 1'b1;
					st_nxt         = ST_SCAN_RD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_SCAN_RD: begin
				if (sts.scan_end) begin
					cmd.scan_stop = 1'b1;
					ret_hunt_nxt  = 1'b1;
					st_nxt        = sts.res_need ? ST_EMIT : ST_HUNT;
				end else begin
					cmd.scan_rd = 1'b1;
					st_nxt      = ST_SCAN_CHK;
				end
			end
			ST_SCAN_CHK: begin
				if (sts.scan_nz) begin
					cmd.scan_found = 1'b1;
					ret_hunt_nxt   = 1'b0;
					st_nxt         = sts.res_need ? ST_EMIT : ST_PAY;
				end else begin
					cmd.scan_close = 1'b1;
					st_nxt         = ST_SCAN_RD;
				end
			end
			ST_PAY: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.pay_acc  = 1'b1;
					ret_hunt_nxt = 1'b0;
					st_nxt       = sts.rem_last ? ST_SEGEND : ST_EMIT;
				end
			end
			ST_SEGEND: begin
				cmd.seg_end = 1'b1;
				st_nxt      = ST_SCAN_RD;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					st_nxt   = ret_hunt_q ? ST_HUNT : ST_PAY;
				end
			end
			default: st_nxt = ST_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_HUNT;
			ret_hunt_q <= 1'b0;
		end else begin
			st_q       <= st_nxt;
			ret_hunt_q <= ret_hunt_nxt;
		end
	end

endmodule

FILE: hw/rtl/ogpd_dp.sv
`timescale 1ns / 1ps
// Datapath of the Ogg page demux core: header fields, lacing table memory,
// timestamp divider, packet bookkeeping and output register. Depends on ogpd_pkg.
module ogpd_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  ogpd_pkg::cmd_t cmd,
	output ogpd_pkg::sts_t sts,
	input  logic [7:0]     in_byte,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           byte_valid,
	output logic [7:0]     boundary_count,
	output logic           is_header,
	output logic           headers_done,
	output logic           pts_valid,
	output logic [63:0]    pts_ms,
	output logic [31:0]    rate_hz,
	output logic [7:0]     channels,
	output logic [31:0]    bitrate_nom
);
	import ogpd_pkg::*;

	logic [1:0]  magic_q;
	logic [4:0]  hdr_idx_q;
	logic [63:0] granule_q;
	logic [7:0]  seg_cnt_q, seg_idx_q, seg_rem_q, seg_len_q, scan_q;
	logic [63:0] page_pts_q;
	logic [1:0]  hdr_pk_q;
	logic [4:0]  fpi_q;
	logic        sig_ok_q;
	logic [31:0] rate_q, br_q;
	logic [7:0]  ch_q, pend_ch_q;
	logic [63:0] pend_q;

	logic [63:0] div_q;
	logic [31:0] rem_q;
	logic [6:0]  div_cnt_q;

	logic [7:0]  res_byte_q, res_closed_q;
	logic        res_bv_q, res_hdr_q, res_done_q, res_final_q;

	logic [7:0]  mem [0:254];
	logic [7:0]  rd_q;

	logic [63:0] prod;
	logic [32:0] r_sh, r_sub;
	logic        q_bit;
	logic [7:0]  rem_nxt;
	logic        do_close, close_final, cap_ok;
	logic [4:0]  gsel;
	logic [4:0]  csel_lo, csel_hi;
	logic [8:0]  seg_idx_inc, scan_inc;

	assign prod = {granule_q[53:0], 10'b0} - {granule_q[59:0], 4'b0} - {granule_q[60:0], 3'b0};
	assign r_sh  = {rem_q, div_q[63]};
	assign r_sub = r_sh - {1'b0, rate_q};
	assign q_bit = (r_sh >= {1'b0, rate_q});

	assign rem_nxt     = (seg_rem_q != 8'd0) ? seg_rem_q - 8'd1 : 8'd0;
	assign seg_idx_inc = {1'b0, seg_idx_q} + 9'd1;
	assign scan_inc    = {1'b0, scan_q} + 9'd1;
	assign gsel        = hdr_idx_q - GRAN_LO;
	assign csel_lo     = fpi_q - 5'd12;
	assign csel_hi     = fpi_q - 5'd20;

	assign do_close    = cmd.scan_close || (cmd.seg_end && (seg_len_q < SEG_FULL));
	assign close_final = cmd.scan_close ? (scan_inc == {1'b0, seg_cnt_q})
	                                    : (seg_idx_inc == {1'b0, seg_cnt_q});
	assign cap_ok      = (hdr_pk_q == 2'd0) && sig_ok_q && (fpi_q >= ID_MIN_LEN);

	always_comb begin
		sts            = '0;
		sts.magic_done = (in_byte == magic_char(magic_q)) && (magic_q == 2'd3);
		sts.hdr_last   = (hdr_idx_q >= HDR_LAST);
		sts.byte_zero  = (in_byte == 8'd0);
		sts.tbl_last   = (seg_idx_inc == {1'b0, seg_cnt_q});
		sts.div_done   = (div_cnt_q == DIV_STEPS) || (rate_q == 32'd0);
		sts.scan_end   = (scan_q >= seg_cnt_q);
		sts.scan_nz    = (rd_q != 8'd0);
		sts.rem_last   = (rem_nxt == 8'd0);
		sts.res_need   = res_bv_q || (res_closed_q != 8'd0);
		sts.out_free   = !out_valid || out_ready;
	end

	// lacing table: written during the table bytes, scanned for the next segment
	always_ff @(posedge clk) begin
		if (cmd.tbl_acc) mem[seg_idx_q] <= in_byte;
		if (cmd.scan_rd) rd_q <= mem[scan_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q    <= 2'd0;
			hdr_idx_q  <= 5'd0;
			granule_q  <= 64'd0;
			seg_cnt_q  <= 8'd0;
			seg_idx_q  <= 8'd0;
			seg_rem_q  <= 8'd0;
			seg_len_q  <= 8'd0;
			scan_q     <= 8'd0;
			page_pts_q <= 64'd0;
			hdr_pk_q   <= 2'd0;
			fpi_q      <= 5'd0;
			sig_ok_q   <= 1'b0;
			rate_q     <= 32'd0;
			br_q       <= 32'd0;
			ch_q       <= 8'd0;
			pend_ch_q  <= 8'd0;
			pend_q     <= 64'd0;
			div_cnt_q  <= 7'd0;
		end else begin
			if (cmd.hunt_acc) begin
				if (in_byte == magic_char(magic_q)) begin
					magic_q <= magic_q + 2'd1;
					if (magic_q == 2'd3) hdr_idx_q <= HDR_FIRST;
				end else begin
					magic_q <= (in_byte == MAGIC_O) ? 2'd1 : 2'd0;
				end
			end
			if (cmd.hdr_acc) begin
				if (hdr_idx_q >= GRAN_LO && hdr_idx_q <= GRAN_HI)
					granule_q[{gsel[2:0], 3'b000} +: 8] <= in_byte;
				if (hdr_idx_q >= HDR_LAST) begin
					seg_cnt_q <= in_byte;
					seg_idx_q <= 8'd0;
					magic_q   <= 2'd0;
				end else begin
					hdr_idx_q <= hdr_idx_q + 5'd1;
				end
			end
			if (cmd.tbl_acc) seg_idx_q <= seg_idx_inc[7:0];
			if (cmd.div_start) div_cnt_q <= 7'd0;
			if (cmd.div_step) div_cnt_q <= div_cnt_q + 7'd1;
			if (cmd.scan_first) begin
				page_pts_q <= (rate_q != 32'd0) ? div_q : 64'd0;
				scan_q     <= 8'd0;
			end
			if (cmd.scan_close) scan_q <= scan_inc[7:0];
			if (cmd.seg_end) scan_q <= seg_idx_inc[7:0];
			if (cmd.scan_found) begin
				seg_idx_q <= scan_q;
				seg_rem_q <= rd_q;
				seg_len_q <= rd_q;
			end
			if (cmd.scan_stop) magic_q <= 2'd0;
			if (cmd.pay_acc) begin
				seg_rem_q <= rem_nxt;
				if (hdr_pk_q == 2'd0) begin
					if (fpi_q == 5'd0) sig_ok_q <= (in_byte == vorbis_char(3'd0));
					else if (fpi_q < 5'd7 && in_byte != vorbis_char(fpi_q[2:0]))
						sig_ok_q <= 1'b0;
					if (fpi_q == 5'd11) pend_ch_q <= in_byte;
					if (fpi_q >= 5'd12 && fpi_q <= 5'd15)
						pend_q[{1'b0, csel_lo[1:0], 3'b000} +: 8] <= in_byte;
					if (fpi_q >= 5'd20 && fpi_q <= 5'd23)
						pend_q[{1'b1, csel_hi[1:0], 3'b000} +: 8] <= in_byte;
					if (fpi_q < ID_MIN_LEN) fpi_q <= fpi_q + 5'd1;
				end
			end
			if (do_close) begin
				if (hdr_pk_q != 2'd3) begin
					if (cap_ok) begin
						rate_q <= pend_q[31:0];
						br_q   <= pend_q[63:32];
						ch_q   <= pend_ch_q;
					end
					hdr_pk_q <= hdr_pk_q + 2'd1;
				end
				fpi_q    <= 5'd0;
				sig_ok_q <= 1'b0;
			end
		end
	end

	// timestamp divider, one quotient bit per cycle; payload regs need no reset
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_q <= prod;
			rem_q <= 32'd0;
		end else if (cmd.div_step) begin
			div_q <= {div_q[62:0], q_bit};
			rem_q <= q_bit ? r_sub[31:0] : r_sh[31:0];
		end
	end

	// result being assembled for the current step
	always_ff @(posedge clk) begin
		if (cmd.div_start || cmd.pay_acc) begin
			res_byte_q   <= cmd.pay_acc ? in_byte : 8'd0;
			res_bv_q     <= cmd.pay_acc;
			res_closed_q <= 8'd0;
			res_hdr_q    <= (hdr_pk_q != 2'd3);
			res_done_q   <= 1'b0;
			res_final_q  <= 1'b0;
		end else if (do_close) begin
			res_closed_q <= res_closed_q + 8'd1;
			res_final_q  <= close_final;
			if (hdr_pk_q == 2'd2) res_done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.emit) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte       <= res_byte_q;
			byte_valid     <= res_bv_q;
			boundary_count <= res_closed_q;
			is_header      <= res_hdr_q;
			headers_done   <= res_done_q;
			pts_valid      <= res_final_q && (res_closed_q != 8'd0);
			pts_ms         <= (res_final_q && (res_closed_q != 8'd0)) ? page_pts_q : 64'd0;
			rate_hz        <= rate_q;
			channels       <= ch_q;
			bitrate_nom    <= br_q;
		end
	end

endmodule

FILE: hw/rtl/ogg_page_demux_core.sv
`timescale 1ns / 1ps
// Channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | in_byte
// out     | out | out_valid / out_ready| out_byte .. bitrate_nom
//
// Hunt, header and table bytes are taken as offered; a payload byte is accepted and emitted.
// A segment-ending byte passes the segment-end state, a read and a check state per lacing
// entry scanned (registered read) and one more read state when the table runs out.
// The last table byte starts the divider (skipped when the rate is 0), then the scan.
// arst_n clears control and captured stream info; the lacing table is not cleared.
// Output stalls hold the next result in the emit state; input waits meanwhile.
// Top level of the Ogg page demux core; depends on ogpd_pkg, ogpd_ctrl, ogpd_dp.
module ogg_page_demux_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic [7:0]  boundary_count,
	output logic        is_header,
	output logic        headers_done,
	output logic        pts_valid,
	output logic [63:0] pts_ms,
	output logic [31:0] rate_hz,
	output logic [7:0]  channels,
	output logic [31:0] bitrate_nom
);
	import ogpd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ogpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ogpd_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.boundary_count (boundary_count),
		.is_header      (is_header),
		.headers_done   (headers_done),
		.pts_valid      (pts_valid),
		.pts_ms         (pts_ms),
		.rate_hz        (rate_hz),
		.channels       (channels),
		.bitrate_nom    (bitrate_nom)
	);

endmodule

FILE: hw/rtl/ogpd_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the Ogg page demux core, bound to the top level.
// Depends only on the top level's ports.
module ogpd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic        byte_valid,
	input logic [7:0]  boundary_count,
	input logic        headers_done,
	input logic        pts_valid,
	input logic [63:0] pts_ms
);

	a_pts_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !pts_valid) |-> (pts_ms == 64'd0))
		else $error("pts_ms nonzero without pts_valid");

	a_boundary_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (boundary_count != 8'd0 && out_byte == 8'd0))
		else $error("boundary-only beat without a packet end");

	a_done_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (headers_done || pts_valid)) |-> (boundary_count != 8'd0))
		else $error("header or page end flagged without a packet end");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("output beat dropped while stalled");

endmodule

bind ogg_page_demux_core ogpd_chk u_ogpd_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.out_byte       (out_byte),
	.byte_valid     (byte_valid),
	.boundary_count (boundary_count),
	.headers_done   (headers_done),
	.pts_valid      (pts_valid),
	.pts_ms         (pts_ms)
);
